FILE: sv/lebuf_pkg.sv
// Shared types and constants for the line edit buffer.
`default_nettype none
package lebuf_pkg;

   // Command codes
   localparam logic [2:0] CMD_INSERT    = 3'd0;
   localparam logic [2:0] CMD_LEFT      = 3'd1;
   localparam logic [2:0] CMD_RIGHT     = 3'd2;
   localparam logic [2:0] CMD_HOME      = 3'd3;
   localparam logic [2:0] CMD_END       = 3'd4;
   localparam logic [2:0] CMD_BACKSPACE = 3'd5;
   localparam logic [2:0] CMD_DELETE    = 3'd6;
   localparam logic [2:0] CMD_CLEAR     = 3'd7;

   // Lowest printable code accepted by insert
   localparam logic [7:0] CHAR_MIN = 8'd32;

   typedef struct packed {
      logic [2:0] command;
      logic [7:0] char_code;
      logic [5:0] read_index;
   } req_type;

   typedef struct packed {
      logic       accepted;
      logic [5:0] cursor_now;
      logic [5:0] length_now;
      logic [7:0] read_char;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;      // capture request
      logic simple;    // apply cursor move or clear
      logic ins_init;  // shift pointer to tail
      logic del_init;  // shift pointer to removed cell
      logic shift_rd;  // read neighbor cell
      logic shift_wr;  // write it one cell over
      logic put;       // store inserted character
      logic del_fin;   // shorten line
      logic fetch;     // read the requested cell
      logic reply;     // present the result
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic is_insert;
      logic is_remove;   // backspace or delete
      logic refuse;      // edit cannot act
      logic shift_done;
   } dp_status_type;

endpackage
`default_nettype wire

FILE: sv/lebuf_datapath.sv
// Datapath of the line edit buffer: text store, cursor, length and result register.
`default_nettype none
module lebuf_datapath #(
   parameter int CAPACITY = 64
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire lebuf_pkg::req_type      req_data,
   input  wire lebuf_pkg::dp_cmd_type   cmd,
   output lebuf_pkg::dp_status_type     status,
   output logic                         rsp_valid,
   output lebuf_pkg::rsp_type           rsp_data
);
   import lebuf_pkg::*;

   localparam int AW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
   localparam int CW = (AW > 6) ? AW : 6;
   localparam logic [AW-1:0] LAST = AW'(CAPACITY - 1);

   logic [7:0] store_mem [CAPACITY];

   req_type       req_ff;
   logic [AW-1:0] cursor_ff, cursor_in;
   logic [AW-1:0] length_ff, length_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic          ok_ff, ok_in;
   logic [7:0]    rdata_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff, rsp_in;

   logic          is_ins, is_bs, is_del;
   logic [AW-1:0] idx_dec, idx_inc, cursor_dec;
   logic          rd_en, wr_en;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [7:0]    wr_data;
   logic [CW-1:0] cursor_wide, length_wide, ridx_wide;

   assign is_ins     = (req_ff.command == CMD_INSERT);
   assign is_bs      = (req_ff.command == CMD_BACKSPACE);
   assign is_del     = (req_ff.command == CMD_DELETE);
   assign idx_dec    = idx_ff - 1'b1;
   assign idx_inc    = idx_ff + 1'b1;
   assign cursor_dec = cursor_ff - 1'b1;

   always_comb begin
      status.is_insert  = is_ins;
      status.is_remove  = is_bs | is_del;
      status.refuse     = 1'b0;
      if (is_ins) begin
         status.refuse = (req_ff.char_code < CHAR_MIN) || (length_ff == LAST);
      end else if (is_bs) begin
         status.refuse = (cursor_ff == '0);
      end else if (is_del) begin
         status.refuse = (cursor_ff == length_ff);
      end
      // insert shifts down to the cursor; removal shifts up to the tail
      status.shift_done = is_ins ? (idx_ff == cursor_ff) : (idx_inc == length_ff);
   end

   // store ports
   assign rd_en   = cmd.shift_rd | cmd.fetch;
   assign rd_addr = cmd.fetch ? AW'(req_ff.read_index) : (is_ins ? idx_dec : idx_inc);
   assign wr_en   = cmd.shift_wr | cmd.put;
   assign wr_addr = cmd.put ? cursor_ff : idx_ff;
   assign wr_data = cmd.put ? req_ff.char_code : rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= store_mem[rd_addr];
      end
   end

   always_comb begin
      cursor_in = cursor_ff;
      length_in = length_ff;
      idx_in    = idx_ff;
      ok_in     = ok_ff;
      if (cmd.load) begin
         ok_in = 1'b0;
      end
      if (cmd.simple) begin
         unique case (req_ff.command)
            CMD_LEFT: begin
               if (cursor_ff != '0) begin
                  cursor_in = cursor_dec;
                  ok_in     = 1'b1;
               end
            end
            CMD_RIGHT: begin
               if (cursor_ff < length_ff) begin
                  cursor_in = cursor_ff + 1'b1;
                  ok_in     = 1'b1;
               end
            end
            CMD_HOME: begin
               if (cursor_ff != '0) begin
                  cursor_in = '0;
                  ok_in     = 1'b1;
               end
            end
            CMD_END: begin
               if (cursor_ff != length_ff) begin
                  cursor_in = length_ff;
                  ok_in     = 1'b1;
               end
            end
            CMD_CLEAR: begin
               cursor_in = '0;
               length_in = '0;
               ok_in     = 1'b1;
            end
            default: begin
               ok_in = ok_ff;
            end
         endcase
      end
      if (cmd.ins_init) begin
         idx_in = length_ff;
      end
      if (cmd.del_init) begin
         idx_in = is_bs ? cursor_dec : cursor_ff;
         if (is_bs) begin
            cursor_in = cursor_dec;
         end
      end
      if (cmd.shift_wr) begin
         idx_in = is_ins ? idx_dec : idx_inc;
      end
      if (cmd.put) begin
         cursor_in = cursor_ff + 1'b1;
         length_in = length_ff + 1'b1;
         ok_in     = 1'b1;
      end
      if (cmd.del_fin) begin
         length_in = length_ff - 1'b1;
         ok_in     = 1'b1;
      end
   end

   // result fields are 6 bits wide
   assign cursor_wide = CW'(cursor_ff);
   assign length_wide = CW'(length_ff);
   assign ridx_wide   = CW'(req_ff.read_index);

   always_comb begin
      rsp_in.accepted   = ok_ff;
      rsp_in.cursor_now = cursor_wide[5:0];
      rsp_in.length_now = length_wide[5:0];
      rsp_in.read_char  = (ridx_wide < length_wide) ? rdata_ff : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff    <= '0;
         length_ff    <= '0;
         idx_ff       <= '0;
         ok_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cursor_ff    <= cursor_in;
         length_ff    <= length_in;
         idx_ff       <= idx_in;
         ok_ff        <= ok_in;
         rsp_valid_ff <= cmd.reply;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.reply) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

FILE: sv/lebuf_ctrl.sv
// Controller state machine of the line edit buffer.
`default_nettype none
module lebuf_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire lebuf_pkg::dp_status_type status,
   output logic                          busy,
   output lebuf_pkg::dp_cmd_type         cmd
);
   import lebuf_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_DECIDE   = 6'b000010,
      ST_SHIFT_RD = 6'b000100,
      ST_SHIFT_WR = 6'b001000,
      ST_FETCH    = 6'b010000,
      ST_REPLY    = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (status.is_insert) begin
               if (status.refuse) begin
                  state_in = ST_FETCH;
               end else begin
                  cmd.ins_init = 1'b1;
                  state_in     = ST_SHIFT_RD;
               end
            end else if (status.is_remove) begin
               if (status.refuse) begin
                  state_in = ST_FETCH;
               end else begin
                  cmd.del_init = 1'b1;
                  state_in     = ST_SHIFT_RD;
               end
            end else begin
               cmd.simple = 1'b1;
               state_in   = ST_FETCH;
            end
         end
         ST_SHIFT_RD: begin
            if (status.shift_done) begin
               cmd.put     = status.is_insert;
               cmd.del_fin = ~status.is_insert;
               state_in    = ST_FETCH;
            end else begin
               cmd.shift_rd = 1'b1;
               state_in     = ST_SHIFT_WR;
            end
         end
         ST_SHIFT_WR: begin
            cmd.shift_wr = 1'b1;
            state_in     = ST_SHIFT_RD;
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_REPLY;
         end
         ST_REPLY: begin
            cmd.reply = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule
`default_nettype wire

FILE: sv/line_edit_buffer.sv
// Top level of the line edit buffer: controller plus datapath.
//
//  channel   ports                     direction  handshake
//  request   start, busy, req_data     in         taken when start & !busy
//  response  rsp_valid, rsp_data       out        one-cycle strobe, never held off
//
// Sequence: a move, clear or refused edit passes through decide, fetch and
// reply from acceptance to its response strobe. An insert, backspace or delete
// that acts also runs the shift loop between decide and fetch, with one store
// read and one store write per cell moved. busy drops as the strobe rises,
// so the next transaction may be taken in the cycle the response shows.
// Reset clears cursor and length; cells beyond the length are never read
// back, so the store needs no clearing pass. The receiver cannot stall.
`default_nettype none
module line_edit_buffer #(
   parameter int CAPACITY = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire lebuf_pkg::req_type req_data,
   output logic                    busy,
   output logic                    rsp_valid,
   output lebuf_pkg::rsp_type      rsp_data
);
   import lebuf_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // sequencing: decode, cell-by-cell shift loop, final read, response
   lebuf_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (dp_status),
      .busy   (busy),
      .cmd    (dp_cmd)
   );

   // text store, cursor/length registers, response register
   lebuf_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (dp_cmd),
      .status    (dp_status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

FILE: bench/testbench.sv
// Self-checking testbench for the line edit buffer: directed and random edit commands.
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import lebuf_pkg::*;

   // Store size under test; the line holds one cell less than this.
   localparam int LINE_CELLS = 64;
   localparam int LINE_MAX   = LINE_CELLS - 1;
   // Worst case per transaction: a store read and a store write per moved cell plus overhead.
   localparam int SETTLE_CYCLES = 2 * LINE_CELLS + 16;
   localparam int CYCLE_LIMIT   = 1_000_000;

   logic    clock;
   logic    reset;
   logic    start;
   req_type req_data;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   line_edit_buffer #(
      .CAPACITY(LINE_CELLS)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_data (req_data),
      .busy     (busy),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   // Shadow of the edit buffer: held text, cursor and length.
   logic [7:0] line_text [LINE_CELLS];
   int         cur_pos;
   int         line_len;

   // Predicted status of every accepted transaction, oldest first.
   rsp_type status_due[$];

   int  mismatch_count;
   int  cycle_count;
   // Random sender gaps on or off; off for the closing stretch.
   bit  gaps_on;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   // Drop the cell at pos, pull the tail left, zero the vacated cell.
   function automatic void remove_cell(input int pos);
      int i;
      for (i = pos; i + 1 < line_len; i++)
         line_text[i] = line_text[i + 1];
      line_text[line_len - 1] = 8'd0;
      line_len--;
   endfunction

   // Apply one command to the shadow line and return the status it yields.
   function automatic rsp_type apply_edit(input req_type item);
      rsp_type outcome;
      logic    ok;
      int      i;
      ok = 1'b0;
      case (item.command)
         CMD_INSERT: begin
            // Control codes and a full line are refused.
            if (item.char_code >= CHAR_MIN && line_len < LINE_MAX) begin
               for (i = line_len; i > cur_pos; i--)
                  line_text[i] = line_text[i - 1];
               line_text[cur_pos] = item.char_code;
               cur_pos++;
               line_len++;
               ok = 1'b1;
            end
         end
         CMD_LEFT: begin
            if (cur_pos != 0) begin
               cur_pos--;
               ok = 1'b1;
            end
         end
         CMD_RIGHT: begin
            if (cur_pos < line_len) begin
               cur_pos++;
               ok = 1'b1;
            end
         end
         CMD_HOME: begin
            if (cur_pos != 0) begin
               cur_pos = 0;
               ok = 1'b1;
            end
         end
         CMD_END: begin
            if (cur_pos != line_len) begin
               cur_pos = line_len;
               ok = 1'b1;
            end
         end
         CMD_BACKSPACE: begin
            if (cur_pos != 0) begin
               remove_cell(cur_pos - 1);
               cur_pos--;
               ok = 1'b1;
            end
         end
         CMD_DELETE: begin
            if (cur_pos < line_len) begin
               remove_cell(cur_pos);
               ok = 1'b1;
            end
         end
         default: begin
            // Clear always acts, even on an empty line.
            for (i = 0; i < LINE_CELLS; i++)
               line_text[i] = 8'd0;
            cur_pos  = 0;
            line_len = 0;
            ok       = 1'b1;
         end
      endcase
      outcome.accepted   = ok;
      outcome.cursor_now = cur_pos[5:0];
      outcome.length_now = line_len[5:0];
      // Reads at or past the end of the line return zero.
      outcome.read_char  = (int'(item.read_index) < line_len) ?
                           line_text[item.read_index] : 8'd0;
      return outcome;
   endfunction

   // ------------------------------------------------------------------
   // Monitor and checker
   // ------------------------------------------------------------------

   // Everything is sampled at the rising edge, before the design's
   // registers update. A status may show in the same cycle that the next
   // transaction is taken, so the check runs before the new prediction.
   always @(posedge clock) begin
      rsp_type want;
      bit      bad;
      if (!reset) begin
         if (rsp_valid) begin
            if (status_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("[%0t] status with no transaction pending: %p", $realtime,
                           rsp_data);
            end else begin
               want = status_due.pop_front();
               bad  = (rsp_data.accepted   !== want.accepted)   ||
                      (rsp_data.cursor_now !== want.cursor_now) ||
                      (rsp_data.length_now !== want.length_now) ||
                      (rsp_data.read_char  !== want.read_char);
               if (bad) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("[%0t] status mismatch: expected acc=%0b cur=%0d len=%0d chr=%0h",
                              $realtime, want.accepted, want.cursor_now,
                              want.length_now, want.read_char);
                     $display("    got acc=%0b cur=%0d len=%0d chr=%0h",
                              rsp_data.accepted, rsp_data.cursor_now,
                              rsp_data.length_now, rsp_data.read_char);
                  end
               end
            end
         end
         if (start && !busy)
            status_due.push_back(apply_edit(req_data));
      end
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // Issue one transaction. Inputs change on the falling edge; the task
   // returns at the rising edge that took the transaction, leaving start
   // high so back-to-back commands need no extra cycle.
   task automatic send_command(input logic [2:0] cmd, input logic [7:0] code,
                               input logic [5:0] idx);
      req_type item;
      int      gap;
      item.command    = cmd;
      item.char_code  = code;
      item.read_index = idx;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 4);
         repeat (gap) begin
            @(negedge clock);
            start <= 1'b0;
         end
      end
      @(negedge clock);
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
   endtask

   // Drop start at the next falling edge.
   task automatic go_quiet();
      @(negedge clock);
      start <= 1'b0;
   endtask

   // Printable most of the time, control codes now and then.
   function automatic logic [7:0] random_char();
      if ($urandom_range(0, 99) < 85)
         return 8'($urandom_range(32, 255));
      return 8'($urandom_range(0, 31));
   endfunction

   // Mostly inside the current line, sometimes anywhere.
   function automatic logic [5:0] random_index();
      if (line_len > 0 && $urandom_range(0, 9) < 7)
         return 6'($urandom_range(0, line_len));
      return 6'($urandom_range(0, 63));
   endfunction

   // Insert with weight ins_pct, clear rarely, else any move or delete.
   function automatic logic [2:0] random_command(input int ins_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r >= 98)
         return CMD_CLEAR;
      if (r < ins_pct)
         return CMD_INSERT;
      return 3'($urandom_range(CMD_LEFT, CMD_DELETE));
   endfunction

   task automatic send_random(input int count, input int ins_pct);
      repeat (count)
         send_command(random_command(ins_pct), random_char(), random_index());
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Empty-line refusals, code limits, every move and both deletes.
   task automatic test_directed();
      send_command(CMD_LEFT,      8'h41, 6'd0);
      send_command(CMD_RIGHT,     8'h41, 6'd0);
      send_command(CMD_HOME,      8'h41, 6'd0);
      send_command(CMD_END,       8'h41, 6'd0);
      send_command(CMD_BACKSPACE, 8'h41, 6'd0);
      send_command(CMD_DELETE,    8'h41, 6'd0);
      send_command(CMD_CLEAR,     8'h00, 6'd63);   // clear of an empty line acts
      send_command(CMD_INSERT,    8'h00, 6'd0);    // control code refused
      send_command(CMD_INSERT,    8'h1F, 6'd0);    // highest control code refused
      send_command(CMD_INSERT,    8'h20, 6'd0);    // lowest printable
      send_command(CMD_INSERT,    8'hFF, 6'd1);
      send_command(CMD_INSERT,    8'h80, 6'd2);
      send_command(CMD_INSERT,    8'h7F, 6'd63);
      send_command(CMD_HOME,      8'h00, 6'd0);
      send_command(CMD_HOME,      8'h00, 6'd0);    // already home
      send_command(CMD_LEFT,      8'h00, 6'd0);    // nothing to the left
      send_command(CMD_RIGHT,     8'h00, 6'd1);
      send_command(CMD_INSERT,    8'h41, 6'd1);    // insert mid-line shifts tail
      send_command(CMD_END,       8'h00, 6'd4);
      send_command(CMD_END,       8'h00, 6'd4);    // already at end
      send_command(CMD_RIGHT,     8'h00, 6'd5);    // nothing to the right
      send_command(CMD_DELETE,    8'h00, 6'd3);    // nothing under cursor
      send_command(CMD_BACKSPACE, 8'h00, 6'd4);    // read just past the end
      send_command(CMD_HOME,      8'h00, 6'd0);
      send_command(CMD_DELETE,    8'h00, 6'd0);
   endtask

   // Fill the line to capacity, bump into the limit, then edit the full line.
   task automatic test_full_line();
      int n;
      send_command(CMD_CLEAR, 8'h00, 6'd0);
      n = 0;
      while (n < LINE_MAX + 3) begin
         if ($urandom_range(0, 5) == 0)
            send_command(3'($urandom_range(CMD_LEFT, CMD_END)), 8'h00, random_index());
         send_command(CMD_INSERT, 8'($urandom_range(32, 255)), random_index());
         n++;
      end
      send_command(CMD_INSERT, 8'h05, 6'd62);      // control code on a full line
      send_command(CMD_END,    8'h00, 6'd63);      // last index is past a full line
      send_command(CMD_INSERT, 8'h7E, 6'd62);
      send_command(CMD_BACKSPACE, 8'h00, 6'd62);
      send_command(CMD_INSERT, 8'h7E, 6'd62);      // refill the freed cell
      send_command(CMD_HOME,   8'h00, 6'd0);
      send_command(CMD_INSERT, 8'h7E, 6'd0);       // full at the head too
      repeat (6)
         send_command(CMD_DELETE, 8'h00, 6'($urandom_range(0, 63)));
      send_random(10, 60);
   endtask

   // Phases of different insert bias so the length sweeps the whole range.
   task automatic test_random_edits();
      int round;
      int bias;
      for (round = 0; round < 12; round++) begin
         case ($urandom_range(0, 2))
            0:       bias = 25;
            1:       bias = 55;
            default: bias = 85;
         endcase
         send_random(50, bias);
      end
   endtask

   // The sender holds off until every pending status has come back.
   task automatic test_drain_pause();
      send_random(30, 70);
      go_quiet();
      while (status_due.size() != 0)
         @(posedge clock);
      send_random(30, 40);
   endtask

   // Closing stretch: back-to-back transactions, no gaps.
   task automatic test_back_to_back();
      gaps_on = 1'b0;
      send_random(80, 60);
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------

   initial begin
      int i;
      start          = 1'b0;
      req_data       = '0;
      reset          = 1'b1;
      mismatch_count = 0;
      cycle_count    = 0;
      gaps_on        = 1'b1;
      cur_pos        = 0;
      line_len       = 0;
      for (i = 0; i < LINE_CELLS; i++)
         line_text[i] = 8'd0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_full_line();
      test_random_edits();
      test_drain_pause();
      test_back_to_back();
      go_quiet();

      // Let the last status arrive, then give the block time to show any
      // stray strobe.
      while (status_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && status_due.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
`default_nettype wire

FILE: filelist.f
sv/lebuf_pkg.sv
sv/lebuf_datapath.sv
sv/lebuf_ctrl.sv
sv/line_edit_buffer.sv
bench/testbench.sv
